FILE: hw/rtl/hse_pkg.sv
// hse_pkg: shared constants and transaction types for heap_sort_engine.
// Used by hse_core and heap_sort_engine; no dependencies.
package hse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int CHILD_W   = IDX_W + 1;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } out_item_t;

  // store write port used while loading
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic signed [31:0] data;
  } load_wr_t;

  // sorted element leaving the core
  typedef struct packed {
    logic               valid;
    logic               last;
    logic signed [31:0] value;
  } emit_t;

endpackage

FILE: hw/rtl/hse_core.sv
// hse_core: element store plus the heap-build, extract and emit sequencer.
// Depends on hse_pkg. Store is one write port, one registered read port.
module hse_core (
  input  logic                    clk,
  input  logic                    rst,
  input  hse_pkg::load_wr_t       ld,
  input  logic                    go,
  input  logic [hse_pkg::CNT_W-1:0] go_len,
  output hse_pkg::emit_t          emit
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_BLD_RD  = 11'b00000000010,
    S_BLD_CAP = 11'b00000000100,
    S_SIFT_L  = 11'b00000001000,
    S_SIFT_R  = 11'b00000010000,
    S_SIFT_C  = 11'b00000100000,
    S_SIFT_W  = 11'b00001000000,
    S_NEXT    = 11'b00010000000,
    S_EX_RD0  = 11'b00100000000,
    S_EX_RDK  = 11'b01000000000,
    S_EMIT    = 11'b10000000000
  } state_t;

  state_t                       state;
  logic                         build;
  logic [hse_pkg::CNT_W-1:0]    len;
  logic [hse_pkg::CNT_W-1:0]    hlen;
  logic [hse_pkg::IDX_W-1:0]    k;
  logic [hse_pkg::IDX_W-1:0]    node;
  logic [hse_pkg::IDX_W-1:0]    bidx;
  logic [hse_pkg::IDX_W-1:0]    e;
  logic                         bvalid;
  logic signed [31:0]           cur;
  logic signed [31:0]           best;
  logic signed [31:0]           tmp;
  logic                         emit_v;
  logic                         emit_last;

  logic [31:0]                  mem [hse_pkg::MAX_ITEMS];
  logic signed [31:0]           rdata;
  logic [hse_pkg::IDX_W-1:0]    raddr;
  logic [hse_pkg::IDX_W-1:0]    waddr;
  logic [31:0]                  wdata;
  logic                         we;

  logic [hse_pkg::CHILD_W-1:0]  lc;
  logic [hse_pkg::CHILD_W-1:0]  rc;
  logic [hse_pkg::CHILD_W-1:0]  hlen_c;
  logic                         lc_in;
  logic                         rc_in;
  logic                         e_last;

  assign lc     = {node, 1'b1};
  assign rc     = {node, 1'b0} + hse_pkg::CHILD_W'(2);
  assign hlen_c = hse_pkg::CHILD_W'(hlen);
  assign lc_in  = lc < hlen_c;
  assign rc_in  = rc < hlen_c;
  assign e_last = (hse_pkg::CNT_W'(e) + hse_pkg::CNT_W'(1)) == len;

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      S_IDLE: begin
        we    = ld.we;
        waddr = ld.addr;
        wdata = ld.data;
      end
      S_BLD_RD: raddr = k - hse_pkg::IDX_W'(1);
      S_SIFT_L: begin
        raddr = lc[hse_pkg::IDX_W-1:0];
        if (!lc_in) begin
          we    = 1'b1;
          waddr = node;
          wdata = cur;
        end
      end
      S_SIFT_R: raddr = rc[hse_pkg::IDX_W-1:0];
      S_SIFT_W: begin
        we    = 1'b1;
        waddr = node;
        wdata = bvalid ? best : cur;
      end
      S_EX_RD0: raddr = '0;
      S_EX_RDK: raddr = k;
      S_EMIT:   raddr = e;
      default: begin
        raddr = '0;
      end
    endcase
    // hole at k receives the old root once k itself has been read
    if (state == S_BLD_CAP && !build) begin
      we    = 1'b1;
      waddr = k;
      wdata = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // S_BLD_CAP doubles as the capture state for extract: cur gets the value
  // read from the sift root (build) or from position k (extract).
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      build     <= 1'b0;
      len       <= '0;
      hlen      <= '0;
      k         <= '0;
      node      <= '0;
      e         <= '0;
      bvalid    <= 1'b0;
      emit_v    <= 1'b0;
      emit_last <= 1'b0;
    end else begin
      emit_v <= (state == S_EMIT);
      case (state)
        S_IDLE: begin
          if (go) begin
            len <= go_len;
            e   <= '0;
            if (go_len < hse_pkg::CNT_W'(2)) begin
              state <= S_EMIT;
            end else begin
              build <= 1'b1;
              k     <= go_len[hse_pkg::CNT_W-1:1];
              hlen  <= go_len;
              state <= S_BLD_RD;
            end
          end
        end
        S_BLD_RD: begin
          node  <= k - hse_pkg::IDX_W'(1);
          state <= S_BLD_CAP;
        end
        S_BLD_CAP: begin
          cur   <= rdata;
          state <= S_SIFT_L;
          if (!build) begin
            node <= '0;
            hlen <= hse_pkg::CNT_W'(k);
          end
        end
        S_SIFT_L: begin
          state <= lc_in ? S_SIFT_R : S_NEXT;
        end
        S_SIFT_R: begin
          if (rdata > cur) begin
            best   <= rdata;
            bidx   <= lc[hse_pkg::IDX_W-1:0];
            bvalid <= 1'b1;
          end else begin
            best   <= cur;
            bvalid <= 1'b0;
          end
          state <= rc_in ? S_SIFT_C : S_SIFT_W;
        end
        S_SIFT_C: begin
          if (rdata > best) begin
            best   <= rdata;
            bidx   <= rc[hse_pkg::IDX_W-1:0];
            bvalid <= 1'b1;
          end
          state <= S_SIFT_W;
        end
        S_SIFT_W: begin
          if (bvalid) begin
            node  <= bidx;
            state <= S_SIFT_L;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (build) begin
            if (k > hse_pkg::IDX_W'(1)) begin
              k     <= k - hse_pkg::IDX_W'(1);
              state <= S_BLD_RD;
            end else begin
              build <= 1'b0;
              k     <= hse_pkg::IDX_W'(len - hse_pkg::CNT_W'(1));
              state <= S_EX_RD0;
            end
          end else if (k > hse_pkg::IDX_W'(1)) begin
            k     <= k - hse_pkg::IDX_W'(1);
            state <= S_EX_RD0;
          end else begin
            e     <= '0;
            state <= S_EMIT;
          end
        end
        S_EX_RD0: state <= S_EX_RDK;
        S_EX_RDK: begin
          tmp   <= rdata;
          state <= S_BLD_CAP;
        end
        S_EMIT: begin
          emit_last <= e_last;
          if (e_last) begin
            state <= S_IDLE;
          end else begin
            e <= e + hse_pkg::IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign emit.valid = emit_v;
  assign emit.last  = emit_last;
  assign emit.value = rdata;

`ifndef NO_ASSERTIONS
  a_emit_follows_read: assert property (@(posedge clk) disable iff (rst)
    emit_v |-> $past(state == S_EMIT))
    else $error("emit strobe without a read in the emit state");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    ld.we |-> state == S_IDLE)
    else $error("load write while sorting");

  a_heap_in_run: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_EMIT) |-> (hlen <= len && len >= hse_pkg::CNT_W'(2)))
    else $error("heap size outside the run");

  a_go_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (go && state == S_IDLE) |=> state != S_IDLE)
    else $error("start of sort lost");
`endif

endmodule

FILE: hw/rtl/heap_sort_engine.sv
// heap_sort_engine: top level; loads elements, tracks count and overflow,
// hands the run to hse_core and returns the sorted transactions.
// Depends on hse_pkg and hse_core.
//
//   channel  ports                    handshake
//   input    item (in_item_t)         accepted when start && !busy
//   output   result (out_item_t)      valid for one cycle while strobe is high
//
// Elements load one per cycle while busy is low; a non-last element returns nothing.
// After the last element the store is heap-sorted: each sift-down level reads
// the children on the single read port and writes the node back; then the
// N results of a run of N elements follow, one per cycle.
// busy stays high from the last element until its final result is strobed.
// Reset clears the count, overflow and sequencer; store contents are kept.
// The receiver cannot stall: results leave at one per cycle.
module heap_sort_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hse_pkg::in_item_t   item,
  output logic                busy,
  output logic                strobe,
  output hse_pkg::out_item_t  result
);

  logic [hse_pkg::CNT_W-1:0] count;
  logic                      ovf_seen;
  logic                      run_ovf;
  logic                      busy_r;
  logic                      accept;
  logic                      room;
  logic                      go;
  logic [hse_pkg::CNT_W-1:0] go_len;
  hse_pkg::load_wr_t         ld;
  hse_pkg::emit_t            emit;

  assign accept = start & ~busy_r;
  assign room   = count < hse_pkg::CNT_W'(hse_pkg::MAX_ITEMS);
  assign go     = accept & item.last;
  assign go_len = room ? count + hse_pkg::CNT_W'(1) : count;

  assign ld.we   = accept & room;
  assign ld.addr = count[hse_pkg::IDX_W-1:0];
  assign ld.data = item.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
      run_ovf  <= 1'b0;
      busy_r   <= 1'b0;
    end else begin
      if (go) begin
        count    <= '0;
        ovf_seen <= 1'b0;
        run_ovf  <= ovf_seen | ~room;
        busy_r   <= 1'b1;
      end else if (accept) begin
        if (room) begin
          count <= count + hse_pkg::CNT_W'(1);
        end else begin
          ovf_seen <= 1'b1;
        end
      end else if (emit.valid && emit.last) begin
        busy_r <= 1'b0;
      end
    end
  end

  hse_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ld     (ld),
    .go     (go),
    .go_len (go_len),
    .emit   (emit)
  );

  assign busy                = busy_r;
  assign strobe              = emit.valid;
  assign result.sorted_value = emit.value;
  assign result.last_out     = emit.last;
  assign result.overflow     = run_ovf;

endmodule

FILE: test/heap_sort_engine_test.sv
`timescale 1ns / 1ps
// heap_sort_engine_test: self-checking testbench for heap_sort_engine.
// Sends sets of signed elements, predicts the ascending output of each run
// and checks every strobed transaction. Depends on hse_pkg and heap_sort_engine.

class sort_checker;
  logic signed [31:0] held [hse_pkg::MAX_ITEMS];
  int held_count;
  bit dropped;
  hse_pkg::out_item_t expected_sorted[$];
  int errors;
  int checked;
  int runs;
  int overflow_runs;

  function void report(string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endfunction

  // store or drop the element; a last element sorts the run
  function void take_element(hse_pkg::in_item_t it);
    logic signed [31:0] key;
    hse_pkg::out_item_t want;
    int j;
    if (held_count < hse_pkg::MAX_ITEMS) begin
      held[held_count] = it.value;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!it.last) return;
    for (int i = 1; i < held_count; i++) begin
      key = held[i];
      j = i - 1;
      while (j >= 0 && held[j] > key) begin
        held[j + 1] = held[j];
        j--;
      end
      held[j + 1] = key;
    end
    for (int i = 0; i < held_count; i++) begin
      want.sorted_value = held[i];
      want.last_out = (i == held_count - 1);
      want.overflow = dropped;
      expected_sorted.push_back(want);
    end
    runs++;
    if (dropped) overflow_runs++;
    held_count = 0;
    dropped = 1'b0;
  endfunction

  function void check_output(hse_pkg::out_item_t got);
    hse_pkg::out_item_t want;
    checked++;
    if (expected_sorted.size() == 0) begin
      report($sformatf("unexpected transaction: expected none, got value=%0d last=%0b ovf=%0b",
                       got.sorted_value, got.last_out, got.overflow));
      return;
    end
    want = expected_sorted.pop_front();
    if (got.sorted_value !== want.sorted_value)
      report($sformatf("sorted_value: expected %0d, got %0d",
                       want.sorted_value, got.sorted_value));
    if (got.last_out !== want.last_out)
      report($sformatf("last_out: expected %0b, got %0b", want.last_out, got.last_out));
    if (got.overflow !== want.overflow)
      report($sformatf("overflow: expected %0b, got %0b", want.overflow, got.overflow));
  endfunction
endclass

module heap_sort_engine_test;

  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;
  localparam int RANDOM_ELEMENTS = 20;

  logic clk;
  logic rst;
  logic start;
  hse_pkg::in_item_t item;
  logic busy;
  logic strobe;
  hse_pkg::out_item_t result;

  sort_checker sb;
  int sent;

  heap_sort_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .strobe(strobe),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) sb.check_output(result);
  end

  task automatic send_element(input logic signed [31:0] v, input logic l);
    @(negedge clk);
    start = 1'b1;
    item = '{value: v, last: l};
    do @(posedge clk); while (busy);
    sb.take_element(item);
    sent++;
  endtask

  // mostly short gaps, now and then a long one; item carries junk while idle
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      item = '{value: $urandom, last: 1'($urandom_range(0, 1))};
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 8) return $signed($urandom_range(0, 8)) - 4;
    if (r == 8) return MOST_POS - $urandom_range(0, 2);
    return MOST_NEG + $urandom_range(0, 2);
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) begin
      idle_gap();
      send_element(pick_value(), i == n - 1);
    end
  endtask

  initial begin
    int r;
    int n;
    int random_sent;
    sb = new();
    sent = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '{value: '0, last: 1'b0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single element, then a pair of extremes
    send_element(MOST_NEG, 1'b1);
    send_element(MOST_POS, 1'b0);
    send_element(MOST_NEG, 1'b1);
    // extremes mixed with duplicates, back to back
    send_element(0, 1'b0);
    send_element(-1, 1'b0);
    send_element(1, 1'b0);
    send_element(MOST_POS, 1'b0);
    send_element(MOST_NEG, 1'b0);
    send_element(-1, 1'b0);
    send_element(0, 1'b0);
    send_element(5, 1'b0);
    send_element(5, 1'b1);
    // already ascending, then descending
    send_element(-3, 1'b0);
    send_element(7, 1'b0);
    send_element(9, 1'b1);
    send_element(40, 1'b0);
    send_element(20, 1'b0);
    send_element(-20, 1'b0);
    send_element(-40, 1'b1);

    // store filled exactly, then overfilled so that the last two elements are dropped
    send_set(hse_pkg::MAX_ITEMS);
    send_set(hse_pkg::MAX_ITEMS + 2);

    random_sent = 0;
    while (random_sent < RANDOM_ELEMENTS) begin
      r = $urandom_range(0, 99);
      if (r < 80) n = $urandom_range(1, 10);
      else if (r < 96) n = $urandom_range(11, 40);
      else n = $urandom_range(hse_pkg::MAX_ITEMS, hse_pkg::MAX_ITEMS + 2);
      if (n > RANDOM_ELEMENTS - random_sent) n = RANDOM_ELEMENTS - random_sent;
      send_set(n);
      random_sent += n;
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.expected_sorted.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d transactions sent in %0d runs, %0d of them with dropped elements",
             sent, sb.runs, sb.overflow_runs);
    $display("%0d sorted transactions checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/hse_pkg.sv
hw/rtl/hse_core.sv
hw/rtl/heap_sort_engine.sv
test/heap_sort_engine_test.sv
